[src/u2c_pkg.sv]
// Shared types, constants and the CP437 glyph lookup for the UTF-8 to CP437 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u2c_pkg;

    localparam logic [7:0] GLYPH_ERROR   = 8'h3F;
    localparam logic [7:0] GLYPH_NEWLINE = 8'h24;
    localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

    // One raw byte of UTF-8 text.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_u2c_in;

    // One CP437 result.
    typedef struct packed {
        logic [7:0] glyph_code;
        logic       final_glyph;
    } t_u2c_out;

    // Work passed from the decoder to the emitter: a run of error glyphs,
    // optionally followed by the glyph of a decoded code point.
    typedef struct packed {
        logic [2:0]  err_count;
        logic        has_glyph;
        logic [20:0] codepoint;
        logic        fin;
    } t_u2c_cmd;

    // Maps a code point to a CP437 byte; newline gives GLYPH_NEWLINE, unmapped GLYPH_ERROR.
    function automatic logic [7:0] glyph_of(input logic [20:0] cp);
        logic [7:0] g;
        g = GLYPH_ERROR;
        if (cp == {13'd0, ASCII_NEWLINE}) begin
            g = GLYPH_NEWLINE;
        end else if (cp < 21'h80) begin
            g = cp[7:0];
        end else if (cp[20:16] == 5'd0) begin
            case (cp[15:0])
                16'h00C7: g = 8'h80;  16'h00FC: g = 8'h81;  16'h00E9: g = 8'h82;
                16'h00E2: g = 8'h83;  16'h00E4: g = 8'h84;  16'h00E0: g = 8'h85;
                16'h00E5: g = 8'h86;  16'h00E7: g = 8'h87;
                16'h00EA: g = 8'h88;  16'h00EB: g = 8'h89;  16'h00E8: g = 8'h8A;
                16'h00EF: g = 8'h8B;  16'h00EE: g = 8'h8C;  16'h00EC: g = 8'h8D;
                16'h00C4: g = 8'h8E;  16'h00C5: g = 8'h8F;
                16'h00C9: g = 8'h90;  16'h00E6: g = 8'h91;  16'h00C6: g = 8'h92;
                16'h00F4: g = 8'h93;  16'h00F6: g = 8'h94;  16'h00F2: g = 8'h95;
                16'h00FB: g = 8'h96;  16'h00F9: g = 8'h97;
                16'h00FF: g = 8'h98;  16'h00D6: g = 8'h99;  16'h00DC: g = 8'h9A;
                16'h00A2: g = 8'h9B;  16'h00A3: g = 8'h9C;  16'h00A5: g = 8'h9D;
                16'h20A7: g = 8'h9E;  16'h0192: g = 8'h9F;
                16'h00E1: g = 8'hA0;  16'h00ED: g = 8'hA1;  16'h00F3: g = 8'hA2;
                16'h00FA: g = 8'hA3;  16'h00F1: g = 8'hA4;  16'h00D1: g = 8'hA5;
                16'h00AA: g = 8'hA6;  16'h00BA: g = 8'hA7;
                16'h00BF: g = 8'hA8;  16'h2310: g = 8'hA9;  16'h00AC: g = 8'hAA;
                16'h00BD: g = 8'hAB;  16'h00BC: g = 8'hAC;  16'h00A1: g = 8'hAD;
                16'h00AB: g = 8'hAE;  16'h00BB: g = 8'hAF;
                16'h2591: g = 8'hB0;  16'h2592: g = 8'hB1;  16'h2593: g = 8'hB2;
                16'h2502: g = 8'hB3;  16'h2524: g = 8'hB4;  16'h2561: g = 8'hB5;
                16'h2562: g = 8'hB6;  16'h2556: g = 8'hB7;
                16'h2555: g = 8'hB8;  16'h2563: g = 8'hB9;  16'h2551: g = 8'hBA;
                16'h2557: g = 8'hBB;  16'h255D: g = 8'hBC;  16'h255C: g = 8'hBD;
                16'h255B: g = 8'hBE;  16'h2510: g = 8'hBF;
                16'h2514: g = 8'hC0;  16'h2534: g = 8'hC1;  16'h252C: g = 8'hC2;
                16'h251C: g = 8'hC3;  16'h2500: g = 8'hC4;  16'h253C: g = 8'hC5;
                16'h255E: g = 8'hC6;  16'h255F: g = 8'hC7;
                16'h255A: g = 8'hC8;  16'h2554: g = 8'hC9;  16'h2569: g = 8'hCA;
                16'h2566: g = 8'hCB;  16'h2560: g = 8'hCC;  16'h2550: g = 8'hCD;
                16'h256C: g = 8'hCE;  16'h2567: g = 8'hCF;
                16'h2568: g = 8'hD0;  16'h2564: g = 8'hD1;  16'h2565: g = 8'hD2;
                16'h2559: g = 8'hD3;  16'h2558: g = 8'hD4;  16'h2552: g = 8'hD5;
                16'h2553: g = 8'hD6;  16'h256B: g = 8'hD7;
                16'h256A: g = 8'hD8;  16'h2518: g = 8'hD9;  16'h250C: g = 8'hDA;
                16'h2588: g = 8'hDB;  16'h2584: g = 8'hDC;  16'h258C: g = 8'hDD;
                16'h2590: g = 8'hDE;  16'h2580: g = 8'hDF;
                16'h03B1: g = 8'hE0;  16'h00DF: g = 8'hE1;  16'h0393: g = 8'hE2;
                16'h03C0: g = 8'hE3;  16'h03A3: g = 8'hE4;  16'h03C3: g = 8'hE5;
                16'h00B5: g = 8'hE6;  16'h03C4: g = 8'hE7;
                16'h03A6: g = 8'hE8;  16'h0398: g = 8'hE9;  16'h03A9: g = 8'hEA;
                16'h03B4: g = 8'hEB;  16'h221E: g = 8'hEC;  16'h03C6: g = 8'hED;
                16'h03B5: g = 8'hEE;  16'h2229: g = 8'hEF;
                16'h2261: g = 8'hF0;  16'h00B1: g = 8'hF1;  16'h2265: g = 8'hF2;
                16'h2264: g = 8'hF3;  16'h2320: g = 8'hF4;  16'h2321: g = 8'hF5;
                16'h00F7: g = 8'hF6;  16'h2248: g = 8'hF7;
                16'h00B0: g = 8'hF8;  16'h2219: g = 8'hF9;  16'h00B7: g = 8'hFA;
                16'h221A: g = 8'hFB;  16'h207F: g = 8'hFC;  16'h00B2: g = 8'hFD;
                16'h25A0: g = 8'hFE;  16'h00A0: g = 8'hFF;
                default:  g = GLYPH_ERROR;
            endcase
        end
        return g;
    endfunction

endpackage

`default_nettype wire

[src/utf8_to_cp437_transcoder_core.sv]
// Top level of the UTF-8 to CP437 transcoder.
//
// Input side is a queue write port: one UTF-8 byte with an end-of-text flag
// is taken on each clock edge where push is high and full is low. Result side
// is a queue read port: while empty is low the oldest CP437 glyph is on
// o_result, and it is taken on an edge where pop is high.
// Each byte gives zero to four glyphs. A decoded glyph or error passes
// through the command queue and the output register to o_result. While the
// receiver keeps popping, bytes are taken one per cycle as long as each
// yields at most one glyph, and the emitter gives one glyph per cycle, so a
// broken sequence with several errors holds the emitter, and the command
// queue of QUEUE_DEPTH entries absorbs the burst before full rises.
// Synchronous active-low reset clears any pending sequence, the command queue
// and the output register. When the receiver stalls, the output register
// holds its glyph, the queue fills and full then stops the input.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_cp437_transcoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    output logic              full,
    input  u2c_pkg::t_u2c_in  i_item,
    output logic              empty,
    input  wire               pop,
    output u2c_pkg::t_u2c_out o_result
);

    logic              q_full;
    logic              q_empty;
    logic              accept;
    logic              cmd_valid;
    logic              cmd_pop;
    u2c_pkg::t_u2c_cmd cmd;
    u2c_pkg::t_u2c_cmd head;

    assign full   = q_full;
    assign accept = push && !q_full;

    u2c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    u2c_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_valid),
        .i_wr_data (cmd),
        .o_full    (q_full),
        .i_rd      (cmd_pop),
        .o_empty   (q_empty),
        .o_head    (head)
    );

    u2c_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

[src/u2c_front.sv]
// UTF-8 decoder front end: gathers sequences and issues emit commands.
`timescale 1ns / 1ps
`default_nettype none

module u2c_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  u2c_pkg::t_u2c_in  i_item,
    output logic              o_cmd_valid,
    output u2c_pkg::t_u2c_cmd o_cmd
);

    logic [20:0] r_cp,   n_cp;
    logic [2:0]  r_len,  n_len;
    logic [2:0]  r_gath, n_gath;

    logic [7:0]  b;
    logic        fin;
    logic        pending;
    logic [2:0]  gath_inc;
    logic [2:0]  err;
    u2c_pkg::t_u2c_cmd cmd;

    assign b        = i_item.text_byte;
    assign fin      = i_item.final_byte;
    assign pending  = (r_len != 3'd0);
    assign gath_inc = r_gath + 3'd1;

    always_comb begin
        n_cp   = r_cp;
        n_len  = r_len;
        n_gath = r_gath;
        err    = 3'd0;
        cmd    = '0;
        if (pending && (b[7:6] == 2'b10)) begin
            n_cp   = {r_cp[14:0], b[5:0]};
            n_gath = gath_inc;
            if (gath_inc >= r_len) begin
                cmd.has_glyph = 1'b1;
                cmd.codepoint = {r_cp[14:0], b[5:0]};
                n_cp   = '0;
                n_len  = 3'd0;
                n_gath = 3'd0;
            end else if (fin) begin
                // Truncated at end of text: one error per held byte, this one included.
                err    = gath_inc;
                n_cp   = '0;
                n_len  = 3'd0;
                n_gath = 3'd0;
            end
        end else begin
            // A broken sequence flushes its held bytes as errors before the
            // breaking byte is decoded on its own.
            err    = pending ? r_gath : 3'd0;
            n_cp   = '0;
            n_len  = 3'd0;
            n_gath = 3'd0;
            if (!b[7]) begin
                cmd.has_glyph = 1'b1;
                cmd.codepoint = {13'd0, b};
            end else if ((b[7:5] == 3'b110) || (b[7:4] == 4'b1110) ||
                         (b[7:3] == 5'b11110)) begin
                if (fin) begin
                    err = err + 3'd1;
                end else begin
                    n_gath = 3'd1;
                    if (b[7:5] == 3'b110) begin
                        n_len = 3'd2;
                        n_cp  = {16'd0, b[4:0]};
                    end else if (b[7:4] == 4'b1110) begin
                        n_len = 3'd3;
                        n_cp  = {17'd0, b[3:0]};
                    end else begin
                        n_len = 3'd4;
                        n_cp  = {18'd0, b[2:0]};
                    end
                end
            end else begin
                err = err + 3'd1;
            end
        end
        cmd.err_count = err;
        cmd.fin       = fin;
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = i_accept && ((err != 3'd0) || cmd.has_glyph);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp   <= '0;
            r_len  <= 3'd0;
            r_gath <= 3'd0;
        end else if (i_accept) begin
            r_cp   <= n_cp;
            r_len  <= n_len;
            r_gath <= n_gath;
        end
    end

`ifndef ASSERT_OFF
    a_gath_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != 3'd0) |-> ((r_gath != 3'd0) && (r_gath < r_len)))
        else $error("front: gathered count out of range for pending sequence");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.final_byte) |=> ((r_len == 3'd0) && (r_gath == 3'd0)))
        else $error("front: sequence still pending after end of text");
`endif

endmodule

`default_nettype wire

[src/u2c_cmd_fifo.sv]
// Short command queue between the decoder and the glyph emitter.
`timescale 1ns / 1ps
`default_nettype none

module u2c_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr,
    input  u2c_pkg::t_u2c_cmd i_wr_data,
    output logic              o_full,
    input  wire               i_rd,
    output logic              o_empty,
    output u2c_pkg::t_u2c_cmd o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    u2c_pkg::t_u2c_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_fire, rd_fire;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_fire = i_wr && !o_full;
    assign rd_fire = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_fire) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + CW'(1);
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_fire && !rd_fire) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("fifo: occupancy did not follow a write");
`endif

endmodule

`default_nettype wire

[src/u2c_back.sv]
// Glyph emitter: expands each command into results and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module u2c_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cmd_empty,
    input  u2c_pkg::t_u2c_cmd i_cmd,
    output logic              o_cmd_pop,
    input  wire               i_pop,
    output logic              o_empty,
    output u2c_pkg::t_u2c_out o_result
);

    logic [2:0]          r_idx, n_idx;
    logic                r_valid, n_valid;
    u2c_pkg::t_u2c_out   r_out, n_out;

    logic [2:0] total;
    logic       last;
    logic       load;

    assign total = i_cmd.err_count + {2'd0, i_cmd.has_glyph};
    assign last  = ((r_idx + 3'd1) == total);
    // The output register takes a new request when it is empty or being drained.
    assign load  = !i_cmd_empty && (!r_valid || i_pop);

    assign o_cmd_pop = load && last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_out   = r_out;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = last ? 3'd0 : r_idx + 3'd1;
            if (r_idx < i_cmd.err_count) begin
                n_out.glyph_code = u2c_pkg::GLYPH_ERROR;
            end else begin
                n_out.glyph_code = u2c_pkg::glyph_of(i_cmd.codepoint);
            end
            n_out.final_glyph = i_cmd.fin && last;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty  = !r_valid;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_empty |-> (r_idx < total))
        else $error("back: emit index beyond the command's result count");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_idx == 3'd0))
        else $error("back: emit index not restarted after a command");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the UTF-8 to CP437 transcoder core.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_BYTES = 104;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int DRAIN_CYCLES = 12;

    // Directed row: byte, final flag, whether a single glyph is typed in, that glyph.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       fin;
        logic       typed;
        logic [7:0] glyph;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              pop = 1'b0;
    u2c_pkg::t_u2c_in  i_item = '0;
    logic              full;
    logic              empty;
    u2c_pkg::t_u2c_out o_result;

    // Upper half of CP437: index k holds the code point that maps to 0x80 + k.
    logic [15:0] cp437_upper [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    t_plan_row directed_plan [26] = '{
        {8'h00, 1'b0, 1'b1, 8'h00},
        {8'h7F, 1'b0, 1'b1, 8'h7F},
        {8'h0A, 1'b0, 1'b1, u2c_pkg::GLYPH_NEWLINE},
        {8'hFF, 1'b0, 1'b1, u2c_pkg::GLYPH_ERROR},
        {8'h80, 1'b0, 1'b1, u2c_pkg::GLYPH_ERROR},
        {8'hC3, 1'b0, 1'b0, 8'h00},
        {8'h87, 1'b0, 1'b0, 8'h00},
        {8'hC2, 1'b0, 1'b0, 8'h00},
        {8'hA0, 1'b0, 1'b0, 8'h00},
        {8'hE2, 1'b0, 1'b0, 8'h00},
        {8'h96, 1'b0, 1'b0, 8'h00},
        {8'h91, 1'b0, 1'b0, 8'h00},
        {8'hF7, 1'b0, 1'b0, 8'h00},
        {8'hBF, 1'b0, 1'b0, 8'h00},
        {8'hBF, 1'b0, 1'b0, 8'h00},
        {8'hBF, 1'b0, 1'b0, 8'h00},
        {8'hC0, 1'b0, 1'b0, 8'h00},
        {8'h8A, 1'b0, 1'b0, 8'h00},
        {8'hF4, 1'b0, 1'b0, 8'h00},
        {8'h80, 1'b0, 1'b0, 8'h00},
        {8'h80, 1'b0, 1'b0, 8'h00},
        {8'hF8, 1'b0, 1'b0, 8'h00},
        {8'hE2, 1'b0, 1'b0, 8'h00},
        {8'h82, 1'b1, 1'b0, 8'h00},
        {8'hC3, 1'b1, 1'b1, u2c_pkg::GLYPH_ERROR},
        {8'h41, 1'b1, 1'b1, 8'h41}
    };

    // Decoder state kept alongside the block.
    logic [20:0] pend_cp = '0;
    logic [2:0]  pend_len = '0;
    logic [2:0]  pend_got = '0;

    u2c_pkg::t_u2c_out step_glyphs[$];
    u2c_pkg::t_u2c_out glyphs_due[$];
    logic [7:0] burst[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  idling = 1'b1;
    bit  hold_wanted = 1'b0;

    utf8_to_cp437_transcoder_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] cp437_code(input logic [20:0] cp);
        logic [7:0] code;
        code = u2c_pkg::GLYPH_ERROR;
        if (cp == 21'h0A) begin
            code = u2c_pkg::GLYPH_NEWLINE;
        end else if (cp < 21'h80) begin
            code = cp[7:0];
        end else begin
            for (int k = 0; k < 128; k++) begin
                if ({5'd0, cp437_upper[k]} == cp) begin
                    code = 8'h80 + k[7:0];
                end
            end
        end
        return code;
    endfunction

    task automatic add_glyph(input logic [7:0] code);
        u2c_pkg::t_u2c_out g;
        g.glyph_code  = code;
        g.final_glyph = 1'b0;
        if (step_glyphs.size() < 4) begin
            step_glyphs.push_back(g);
        end
    endtask

    // Every byte held by a pending sequence turns into an error glyph.
    task automatic flush_pending();
        for (int k = 0; k < pend_got && k < 4; k++) begin
            add_glyph(u2c_pkg::GLYPH_ERROR);
        end
        pend_cp  = '0;
        pend_len = '0;
        pend_got = '0;
    endtask

    task automatic decode_fresh(input logic [7:0] b, input logic fin);
        logic [2:0] len;
        logic [20:0] bits;
        len  = '0;
        bits = '0;
        casez (b)
            8'b0???????: add_glyph(cp437_code({13'd0, b}));
            8'b110?????: begin len = 3'd2; bits = {16'd0, b[4:0]}; end
            8'b1110????: begin len = 3'd3; bits = {17'd0, b[3:0]}; end
            8'b11110???: begin len = 3'd4; bits = {18'd0, b[2:0]}; end
            default:     add_glyph(u2c_pkg::GLYPH_ERROR);
        endcase
        if (len != 0) begin
            if (fin) begin
                add_glyph(u2c_pkg::GLYPH_ERROR);
            end else begin
                pend_cp  = bits;
                pend_len = len;
                pend_got = 3'd1;
            end
        end
    endtask

    // Works out the glyphs that one accepted byte gives, into step_glyphs.
    task automatic decode_byte(input u2c_pkg::t_u2c_in it);
        u2c_pkg::t_u2c_out last;
        step_glyphs.delete();
        if (pend_len != 0 && it.text_byte[7:6] == 2'b10) begin
            pend_cp  = {pend_cp[14:0], it.text_byte[5:0]};
            pend_got = pend_got + 3'd1;
            if (pend_got >= pend_len) begin
                add_glyph(cp437_code(pend_cp));
                pend_cp  = '0;
                pend_len = '0;
                pend_got = '0;
            end else if (it.final_byte) begin
                flush_pending();
            end
        end else begin
            if (pend_len != 0) begin
                flush_pending();
            end
            decode_fresh(it.text_byte, it.final_byte);
        end
        if (it.final_byte && step_glyphs.size() > 0) begin
            last = step_glyphs.pop_back();
            last.final_glyph = 1'b1;
            step_glyphs.push_back(last);
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_glyph(input u2c_pkg::t_u2c_out got);
        u2c_pkg::t_u2c_out want;
        if (glyphs_due.size() == 0) begin
            flag_mismatch($sformatf("glyph %02h arrived with nothing due", got.glyph_code));
        end else begin
            want = glyphs_due.pop_front();
            if (got.glyph_code !== want.glyph_code) begin
                flag_mismatch($sformatf("glyph_code %02h, due %02h",
                                        got.glyph_code, want.glyph_code));
            end
            if (got.final_glyph !== want.final_glyph) begin
                flag_mismatch($sformatf("final_glyph %0b, due %0b (glyph %02h)",
                                        got.final_glyph, want.final_glyph, want.glyph_code));
            end
        end
    endtask

    // Offers one request and returns at the edge at which it is taken.
    task automatic offer(input u2c_pkg::t_u2c_in it);
        if (idling && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
        end while (full);
    endtask

    // Appends the UTF-8 form of cp in exactly len bytes; a long len gives an overlong form.
    task automatic append_seq(input logic [20:0] cp, input int len);
        case (len)
            1: burst.push_back({1'b0, cp[6:0]});
            2: begin
                burst.push_back({3'b110, cp[10:6]});
                burst.push_back({2'b10, cp[5:0]});
            end
            3: begin
                burst.push_back({4'b1110, cp[15:12]});
                burst.push_back({2'b10, cp[11:6]});
                burst.push_back({2'b10, cp[5:0]});
            end
            default: begin
                burst.push_back({5'b11110, cp[20:18]});
                burst.push_back({2'b10, cp[17:12]});
                burst.push_back({2'b10, cp[11:6]});
                burst.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random pauses, one long hold-off to fill the block, none near the end.
    initial begin
        int rest;
        rest = 0;
        wait (i_rst_n === 1'b1);
        pop <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                check_glyph(o_result);
            end
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                pop <= 1'b1;
            end else if (rest > 0) begin
                rest--;
                if (rest == 0) begin
                    pop <= 1'b1;
                end
            end else if (idling && $urandom_range(0, 7) == 0) begin
                rest = $urandom_range(1, 13);
                pop <= 1'b0;
            end
        end
    end

    initial begin
        t_plan_row         row;
        u2c_pkg::t_u2c_in  item;
        u2c_pkg::t_u2c_out want;
        int        sent;
        int        kind;
        int        len;
        int        keep;
        logic [7:0]  breaker;
        logic [20:0] cp;

        sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            row = directed_plan[r];
            item.text_byte  = row.text_byte;
            item.final_byte = row.fin;
            offer(item);
            decode_byte(item);
            if (row.typed) begin
                want.glyph_code  = row.glyph;
                want.final_glyph = row.fin;
                glyphs_due.push_back(want);
            end else begin
                foreach (step_glyphs[k]) glyphs_due.push_back(step_glyphs[k]);
            end
        end

        while (sent < RANDOM_BYTES) begin
            burst.delete();
            kind = $urandom_range(0, 99);
            if (kind < 22) begin
                cp = ($urandom_range(0, 7) == 0) ? 21'h0A : 21'($urandom_range(0, 8'h7F));
                append_seq(cp, 1);
            end else if (kind < 42) begin
                cp = {5'd0, cp437_upper[$urandom_range(0, 127)]};
                append_seq(cp, (cp < 21'h800) ? 2 : 3);
            end else if (kind < 55) begin
                append_seq(21'($urandom_range(21'h80, 21'h7FF)), 2);
            end else if (kind < 65) begin
                append_seq(21'($urandom_range(21'h800, 21'hFFFF)), 3);
            end else if (kind < 72) begin
                append_seq(21'($urandom_range(21'h10000, 21'h1FFFFF)), 4);
            end else if (kind < 79) begin
                // Often overlong: a code point up to 0x7FF in two to four bytes.
                cp = ($urandom_range(0, 2) == 0) ? 21'h0A : 21'($urandom_range(0, 21'h7FF));
                append_seq(cp, $urandom_range(2, 4));
            end else if (kind < 91) begin
                // A sequence cut short by a byte that is not a continuation.
                len = $urandom_range(2, 4);
                append_seq(21'($urandom), len);
                keep = $urandom_range(1, len - 1);
                while (burst.size() > keep) void'(burst.pop_back());
                do begin
                    breaker = 8'($urandom_range(0, 255));
                end while (breaker[7:6] == 2'b10);
                burst.push_back(breaker);
            end else begin
                burst.push_back(8'($urandom_range(0, 255)));
            end

            foreach (burst[k]) begin
                item.text_byte  = burst[k];
                item.final_byte = ($urandom_range(0, 15) == 0);
                // Idling runs in phases: on, a quiet stretch, on again, then off to the end.
                idling = (sent < 50) || (sent >= 65 && sent < 85);
                if (sent == 30) begin
                    hold_wanted = 1'b1;
                end
                offer(item);
                decode_byte(item);
                foreach (step_glyphs[j]) glyphs_due.push_back(step_glyphs[j]);
                sent++;
            end
        end
        push <= 1'b0;

        while (glyphs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
